### rtl/gfmpi_pkg.sv
// Shared types, constants, polynomial table and microcode program of the GF(2^n) unit.
`default_nettype none

package gfmpi_pkg;

    // Width of the element, exponent and result ports.
    localparam int DATA_W = 64;
    // Width of the field degree register.
    localparam int DEG_W = 7;
    // Largest degree the polynomial table covers.
    localparam int TABLE_MAX = 64;
    // Multiplier bits consumed per clock by the digit-serial multiplier.
    localparam int MUL_DIGIT = 4;
    // Width of the microcode step counter.
    localparam int PC_W = 4;

    typedef logic [PC_W-1:0] t_pc;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_MUL  = 2'd0,
        CMD_POW  = 2'd1,
        CMD_INV  = 2'd2,
        CMD_RSVD = 2'd3
    } t_cmd;

    // Datapath operations selected by a control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC_ONE,
        OP_ACC_ZERO,
        OP_SET_ERR,
        OP_INV_SETUP,
        OP_MUL_AB,
        OP_MUL_ACC,
        OP_SQR,
        OP_SHR_E,
        OP_DONE
    } t_dp_op;

    // Jump conditions of a control word.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_CMD_MUL,
        COND_CMD_POW,
        COND_CMD_RSVD,
        COND_A_ZERO,
        COND_E_LSB_CLR,
        COND_E_UPPER_ZERO
    } t_cond;

    // One control word of the program.
    typedef struct packed {
        t_dp_op op;
        t_cond  cond;
        t_pc    target;
    } t_ucode;

    // Sequencer to datapath control.
    typedef struct packed {
        logic   load;
        t_dp_op op;
        logic   mul_start;
    } t_ctrl;

    // Datapath to sequencer status.
    typedef struct packed {
        t_cmd cmd;
        logic a_zero;
        logic e_lsb;
        logic e_upper_zero;
        logic mul_done;
    } t_status;

    // Program addresses.
    localparam t_pc PC_ENTRY    = 4'd0;
    localparam t_pc PC_CMD_POW  = 4'd1;
    localparam t_pc PC_CMD_RSVD = 4'd2;
    localparam t_pc PC_CHK_ZERO = 4'd3;
    localparam t_pc PC_INV      = 4'd4;
    localparam t_pc PC_LOOP     = 4'd5;
    localparam t_pc PC_MUL_ACC  = 4'd6;
    localparam t_pc PC_SHIFT    = 4'd7;
    localparam t_pc PC_SQR      = 4'd8;
    localparam t_pc PC_DONE     = 4'd9;
    localparam t_pc PC_MUL      = 4'd10;

    // Low terms of the reduction polynomial x^n + low, indexed by n.
    localparam logic [7:0] LOW_TERMS [0:TABLE_MAX] = '{
        8'd0,   8'd0,   8'd3,   8'd3,   8'd3,   8'd5,   8'd3,   8'd3,
        8'd27,  8'd3,   8'd9,   8'd5,   8'd9,   8'd27,  8'd33,  8'd3,
        8'd43,  8'd9,   8'd9,   8'd39,  8'd9,   8'd5,   8'd3,   8'd33,
        8'd27,  8'd9,   8'd27,  8'd39,  8'd3,   8'd5,   8'd3,   8'd9,
        8'd141, 8'd75,  8'd27,  8'd5,   8'd53,  8'd63,  8'd99,  8'd17,
        8'd57,  8'd9,   8'd39,  8'd89,  8'd33,  8'd27,  8'd3,   8'd33,
        8'd45,  8'd113, 8'd29,  8'd75,  8'd9,   8'd71,  8'd125, 8'd71,
        8'd149, 8'd17,  8'd99,  8'd123, 8'd3,   8'd39,  8'd105, 8'd3,
        8'd27
    };

    function automatic logic [7:0] low_term(input logic [DEG_W-1:0] n);
        logic [7:0] v;
        v = 8'd0;
        if (n <= DEG_W'(TABLE_MAX)) begin
            v = LOW_TERMS[n];
        end
        return v;
    endfunction

    // Program: multiply, right-to-left square-and-multiply, inverse as a^(2^n-2).
    function automatic t_ucode ucode(input t_pc pc);
        t_ucode w;
        unique case (pc)
            PC_ENTRY:    w = '{op: OP_NONE,      cond: COND_CMD_MUL,      target: PC_MUL};
            PC_CMD_POW:  w = '{op: OP_ACC_ONE,   cond: COND_CMD_POW,      target: PC_LOOP};
            PC_CMD_RSVD: w = '{op: OP_ACC_ZERO,  cond: COND_CMD_RSVD,     target: PC_DONE};
            PC_CHK_ZERO: w = '{op: OP_SET_ERR,   cond: COND_A_ZERO,       target: PC_DONE};
            PC_INV:      w = '{op: OP_INV_SETUP, cond: COND_ALWAYS,       target: PC_LOOP};
            PC_LOOP:     w = '{op: OP_NONE,      cond: COND_E_LSB_CLR,    target: PC_SHIFT};
            PC_MUL_ACC:  w = '{op: OP_MUL_ACC,   cond: COND_NEVER,        target: PC_ENTRY};
            PC_SHIFT:    w = '{op: OP_SHR_E,     cond: COND_E_UPPER_ZERO, target: PC_DONE};
            PC_SQR:      w = '{op: OP_SQR,       cond: COND_ALWAYS,       target: PC_LOOP};
            PC_DONE:     w = '{op: OP_DONE,      cond: COND_NEVER,        target: PC_ENTRY};
            PC_MUL:      w = '{op: OP_MUL_AB,    cond: COND_ALWAYS,       target: PC_DONE};
            default:     w = '{op: OP_NONE,      cond: COND_NEVER,        target: PC_ENTRY};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/gfmpi_mul.sv
// Digit-serial GF(2^n) multiplier on left-aligned elements with interleaved reduction.
`default_nettype none

module gfmpi_mul #(
    parameter int W = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [W-1:0]                       i_x,
    input  wire logic [W-1:0]                       i_y,
    input  wire logic [W-1:0]                       i_poly,
    input  wire logic [gfmpi_pkg::DEG_W-1:0]        i_degree,
    output logic      [W-1:0]                       o_prod,
    output logic                                    o_done
);

    localparam int D  = gfmpi_pkg::MUL_DIGIT;
    localparam int XW = ((W + D - 1) / D) * D;
    localparam int CW = gfmpi_pkg::DEG_W;

    logic [XW-1:0] r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;

    logic [W-1:0]  n_acc;
    logic          last;

    // Up to D MSB-first steps: shift, fold the overflow bit back, add y.
    always_comb begin
        logic [W-1:0] acc_v;
        logic         carry;
        acc_v = r_acc;
        carry = 1'b0;
        for (int k = 0; k < D; k++) begin
            if ((r_cnt + CW'(k)) < i_degree) begin
                carry = acc_v[W-1];
                acc_v = (acc_v << 1) ^ (carry ? i_poly : '0) ^ (r_x[XW-1-k] ? r_y : '0);
            end
        end
        n_acc = acc_v;
    end

    assign last = (r_cnt + CW'(D)) >= i_degree;

    // Run and done control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && last;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && last) begin
                r_run <= 1'b0;
            end
        end
    end

    // Operand shift register, accumulator and step count.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= XW'(i_x) << (XW - W);
            r_y   <= i_y;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            r_x   <= r_x << D;
            r_acc <= n_acc;
            r_cnt <= r_cnt + CW'(D);
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

### rtl/gfmpi_dp.sv
// Datapath of the GF(2^n) unit: operand, accumulator and exponent registers and the multiplier.
`default_nettype none

module gfmpi_dp #(
    parameter int W = 64,
    localparam int SW = (W > 1) ? $clog2(W) : 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire gfmpi_pkg::t_ctrl                   i_ctrl,
    input  wire logic [1:0]                         i_command,
    input  wire logic [gfmpi_pkg::DATA_W-1:0]       i_operand_a,
    input  wire logic [gfmpi_pkg::DATA_W-1:0]       i_operand_b,
    input  wire logic [gfmpi_pkg::DATA_W-1:0]       i_exponent,
    input  wire logic [gfmpi_pkg::DEG_W-1:0]        i_degree,
    input  wire logic [SW-1:0]                      i_shift,
    output gfmpi_pkg::t_status                      o_status,
    output logic                                    o_valid,
    output logic      [gfmpi_pkg::DATA_W-1:0]       o_result,
    output logic                                    o_error
);

    localparam int DW  = gfmpi_pkg::DATA_W;
    localparam int DGW = gfmpi_pkg::DEG_W;

    gfmpi_pkg::t_cmd r_cmd;
    logic [W-1:0]    r_base;
    logic [W-1:0]    r_opb;
    logic [W-1:0]    r_acc;
    logic [W-1:0]    r_poly;
    logic [DW-1:0]   r_exp;
    logic            r_err;
    logic            r_valid;
    logic [DW-1:0]   r_result;
    logic            r_error;

    logic [W-1:0]    a_low;
    logic [W-1:0]    b_low;
    logic [W-1:0]    a_al;
    logic [W-1:0]    b_al;
    logic [W-1:0]    poly_al;
    logic [W-1:0]    one_al;
    logic [W-1:0]    res_w;
    logic [DGW-1:0]  inv_sh;
    logic [DW-1:0]   inv_exp;
    logic [W-1:0]    mul_y;
    logic [W-1:0]    mul_prod;
    logic            mul_done;

    // Elements are held left-aligned: bit n-1 of the element sits at bit W-1.
    assign a_low   = i_operand_a[W-1:0];
    assign b_low   = i_operand_b[W-1:0];
    assign a_al    = a_low << i_shift;
    assign b_al    = b_low << i_shift;
    assign poly_al = W'(gfmpi_pkg::low_term(i_degree)) << i_shift;
    assign one_al  = W'(1) << i_shift;
    assign res_w   = r_acc >> i_shift;

    // Inverse exponent 2^n - 2: n low ones with the lowest one cleared.
    assign inv_sh  = DGW'(DW) - i_degree;
    assign inv_exp = ({DW{1'b1}} >> inv_sh) & ~DW'(1);

    // Second multiplier operand; the first is always the base.
    always_comb begin
        unique case (i_ctrl.op)
            gfmpi_pkg::OP_MUL_AB:  mul_y = r_opb;
            gfmpi_pkg::OP_MUL_ACC: mul_y = r_acc;
            default:               mul_y = r_base;
        endcase
    end

    gfmpi_mul #(
        .W(W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_ctrl.mul_start),
        .i_x      (r_base),
        .i_y      (mul_y),
        .i_poly   (r_poly),
        .i_degree (i_degree),
        .o_prod   (mul_prod),
        .o_done   (mul_done)
    );

    // Register updates for the current control word.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= gfmpi_pkg::t_cmd'(i_command);
            r_base <= a_al;
            r_opb  <= b_al;
            r_exp  <= i_exponent;
            r_poly <= poly_al;
            r_err  <= 1'b0;
        end else begin
            unique case (i_ctrl.op)
                gfmpi_pkg::OP_NONE: begin
                end
                gfmpi_pkg::OP_ACC_ONE: begin
                    r_acc <= one_al;
                end
                gfmpi_pkg::OP_ACC_ZERO: begin
                    r_acc <= '0;
                end
                gfmpi_pkg::OP_SET_ERR: begin
                    r_err <= (r_base == '0);
                end
                gfmpi_pkg::OP_INV_SETUP: begin
                    r_acc <= one_al;
                    r_exp <= inv_exp;
                end
                gfmpi_pkg::OP_MUL_AB, gfmpi_pkg::OP_MUL_ACC: begin
                    if (mul_done) begin
                        r_acc <= mul_prod;
                    end
                end
                gfmpi_pkg::OP_SQR: begin
                    if (mul_done) begin
                        r_base <= mul_prod;
                    end
                end
                gfmpi_pkg::OP_SHR_E: begin
                    r_exp <= r_exp >> 1;
                end
                gfmpi_pkg::OP_DONE: begin
                    r_result <= DW'(res_w);
                    r_error  <= r_err;
                end
                default: begin
                end
            endcase
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_ctrl.op == gfmpi_pkg::OP_DONE);
        end
    end

    assign o_status.cmd          = r_cmd;
    assign o_status.a_zero       = (r_base == '0);
    assign o_status.e_lsb        = r_exp[0];
    assign o_status.e_upper_zero = (r_exp[DW-1:1] == '0);
    assign o_status.mul_done     = mul_done;

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_error  = r_error;

endmodule

`default_nettype wire

### rtl/gfmpi_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
`default_nettype none

module gfmpi_seq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire gfmpi_pkg::t_status     i_status,
    output gfmpi_pkg::t_ctrl            o_ctrl,
    output logic                        o_busy
);

    logic             r_run;
    logic             r_wait;
    gfmpi_pkg::t_pc   r_pc;

    gfmpi_pkg::t_ucode uw;
    logic              is_mul;
    logic              step_done;
    logic              take;
    logic              accept;

    assign uw     = gfmpi_pkg::ucode(r_pc);
    assign is_mul = (uw.op == gfmpi_pkg::OP_MUL_AB) || (uw.op == gfmpi_pkg::OP_MUL_ACC)
                 || (uw.op == gfmpi_pkg::OP_SQR);
    assign step_done = r_run && (!is_mul || i_status.mul_done);
    assign accept    = i_start && !r_run;

    // Jump condition of the current control word.
    always_comb begin
        unique case (uw.cond)
            gfmpi_pkg::COND_NEVER:        take = 1'b0;
            gfmpi_pkg::COND_ALWAYS:       take = 1'b1;
            gfmpi_pkg::COND_CMD_MUL:      take = (i_status.cmd == gfmpi_pkg::CMD_MUL);
            gfmpi_pkg::COND_CMD_POW:      take = (i_status.cmd == gfmpi_pkg::CMD_POW);
            gfmpi_pkg::COND_CMD_RSVD:     take = (i_status.cmd == gfmpi_pkg::CMD_RSVD);
            gfmpi_pkg::COND_A_ZERO:       take = i_status.a_zero;
            gfmpi_pkg::COND_E_LSB_CLR:    take = !i_status.e_lsb;
            gfmpi_pkg::COND_E_UPPER_ZERO: take = i_status.e_upper_zero;
        endcase
    end

    // Step counter and multiply wait flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_wait <= 1'b0;
            r_pc   <= gfmpi_pkg::PC_ENTRY;
        end else if (accept) begin
            r_run  <= 1'b1;
            r_wait <= 1'b0;
            r_pc   <= gfmpi_pkg::PC_ENTRY;
        end else if (step_done) begin
            r_wait <= 1'b0;
            r_pc   <= take ? uw.target : r_pc + 1'b1;
            if (uw.op == gfmpi_pkg::OP_DONE) begin
                r_run <= 1'b0;
            end
        end else if (r_run && is_mul) begin
            r_wait <= 1'b1;
        end
    end

    assign o_ctrl.load      = accept;
    assign o_ctrl.op        = r_run ? uw.op : gfmpi_pkg::OP_NONE;
    assign o_ctrl.mul_start = r_run && is_mul && !r_wait;
    assign o_busy           = r_run;

endmodule

`default_nettype wire

### rtl/gf2n_multiply_power_inverse_unit.sv
// Top level of the GF(2^n) multiply, power and inverse unit.
//
// Arithmetic in GF(2^n) with n set by the field degree register (0 acts as 1, values above
// MAX_DEGREE act as MAX_DEGREE; reset value 8), reduced by x^n plus a fixed low-term pattern.
// A request is taken when start is high and busy is low; busy then stays high until the
// result has been produced, and the result appears on o_result and o_error for exactly one
// cycle with o_valid high, so the receiver must take it then. One multiply runs on a
// digit-serial multiplier that handles four bits of the operand per clock. An inverse runs
// as a power with exponent 2^n - 2. The degree register may be written only while busy is
// low and no result is still due.
`default_nettype none

module gf2n_multiply_power_inverse_unit #(
    parameter int MAX_DEGREE = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [gfmpi_pkg::DEG_W-1:0]        i_cfg_wdata,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         i_command,
    input  wire logic [gfmpi_pkg::DATA_W-1:0]       i_operand_a,
    input  wire logic [gfmpi_pkg::DATA_W-1:0]       i_operand_b,
    input  wire logic [gfmpi_pkg::DATA_W-1:0]       i_exponent,
    output logic                                    o_valid,
    output logic      [gfmpi_pkg::DATA_W-1:0]       o_result,
    output logic                                    o_error
);

    localparam int DGW = gfmpi_pkg::DEG_W;
    localparam int SW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic [DGW-1:0] r_cfg;
    logic [DGW-1:0] degree;
    logic [DGW-1:0] shift_full;
    logic [SW-1:0]  shift;

    gfmpi_pkg::t_ctrl   ctrl;
    gfmpi_pkg::t_status status;

    // Field degree register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= DGW'(8);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Effective degree and the alignment shift that puts bit n-1 at the top.
    always_comb begin
        priority if (r_cfg == '0) begin
            degree = DGW'(1);
        end else if (r_cfg > DGW'(MAX_DEGREE)) begin
            degree = DGW'(MAX_DEGREE);
        end else begin
            degree = r_cfg;
        end
    end

    assign shift_full = DGW'(MAX_DEGREE) - degree;
    assign shift      = shift_full[SW-1:0];

    gfmpi_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    gfmpi_dp #(
        .W(MAX_DEGREE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_command   (i_command),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_exponent  (i_exponent),
        .i_degree    (degree),
        .i_shift     (shift),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .o_error     (o_error)
    );

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the GF(2^n) multiply, power and inverse unit.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = gfmpi_pkg::DATA_W;
    localparam int DEG_W  = gfmpi_pkg::DEG_W;

    // Cycles without any accepted request or result before the run is abandoned.
    localparam int QUIET_LIMIT = 10000;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    // Low terms of the reduction polynomial x^n + tail, indexed by the degree n.
    localparam logic [7:0] POLY_TAIL [0:64] = '{
        8'd0,   8'd0,   8'd3,   8'd3,   8'd3,   8'd5,   8'd3,   8'd3,
        8'd27,  8'd3,   8'd9,   8'd5,   8'd9,   8'd27,  8'd33,  8'd3,
        8'd43,  8'd9,   8'd9,   8'd39,  8'd9,   8'd5,   8'd3,   8'd33,
        8'd27,  8'd9,   8'd27,  8'd39,  8'd3,   8'd5,   8'd3,   8'd9,
        8'd141, 8'd75,  8'd27,  8'd5,   8'd53,  8'd63,  8'd99,  8'd17,
        8'd57,  8'd9,   8'd39,  8'd89,  8'd33,  8'd27,  8'd3,   8'd33,
        8'd45,  8'd113, 8'd29,  8'd75,  8'd9,   8'd71,  8'd125, 8'd71,
        8'd149, 8'd17,  8'd99,  8'd123, 8'd3,   8'd39,  8'd105, 8'd3,
        8'd27
    };

    typedef struct {
        logic [DATA_W-1:0] elem;
        logic              err;
    } t_field_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [DEG_W-1:0]  i_cfg_wdata;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [DATA_W-1:0] i_operand_a;
    logic [DATA_W-1:0] i_operand_b;
    logic [DATA_W-1:0] i_exponent;
    logic              o_valid;
    logic [DATA_W-1:0] o_result;
    logic              o_error;

    // Degree register as last written, and the results still owed by the unit.
    logic [DEG_W-1:0]  degree_cfg;
    t_field_out        pending_results[$];
    int                n_sent;
    int                n_checked;
    int                n_fail;
    int                n_settings;
    int                quiet_cycles;
    bit                steady;

    gf2n_multiply_power_inverse_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_exponent  (i_exponent),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .o_error     (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The register value 0 behaves as degree 1 and anything above 64 as degree 64.
    function automatic int active_degree(logic [DEG_W-1:0] cfg);
        if (cfg == '0) return 1;
        if (cfg > DEG_W'(64)) return 64;
        return int'(cfg);
    endfunction

    function automatic logic [DATA_W-1:0] elem_mask(int n);
        return (n >= 64) ? ALL_ONES : ((64'd1 << n) - 64'd1);
    endfunction

    // Carry-less product followed by reduction from the top term down.
    function automatic logic [DATA_W-1:0] gf_product(int n, logic [DATA_W-1:0] a,
                                                     logic [DATA_W-1:0] b);
        logic [127:0]      prod;
        logic [DATA_W-1:0] m;
        m = elem_mask(n);
        a = a & m;
        b = b & m;
        prod = '0;
        for (int i = 0; i < n; i++) begin
            if (a[i]) prod = prod ^ ({64'd0, b} << i);
        end
        for (int i = n - 2; i >= 0; i--) begin
            if (prod[n + i]) prod = prod ^ ({120'd0, POLY_TAIL[n]} << i);
        end
        return prod[63:0] & m;
    endfunction

    // Right-to-left square-and-multiply; a zero exponent gives 1.
    function automatic logic [DATA_W-1:0] gf_power(int n, logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] e);
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] acc;
        base = a & elem_mask(n);
        acc = 64'd1;
        do begin
            if (e[0]) acc = gf_product(n, acc, base);
            e = e >> 1;
            if (e != '0) base = gf_product(n, base, base);
        end while (e != '0);
        return acc;
    endfunction

    // Expected outcome of one request under the current degree.
    function automatic t_field_out field_result(gfmpi_pkg::t_cmd cmd, logic [DATA_W-1:0] a,
                                                logic [DATA_W-1:0] b,
                                                logic [DATA_W-1:0] e);
        t_field_out        r;
        int                n;
        logic [DATA_W-1:0] am;
        logic [DATA_W-1:0] inv_exp;
        n = active_degree(degree_cfg);
        am = a & elem_mask(n);
        r.elem = '0;
        r.err = 1'b0;
        case (cmd)
            gfmpi_pkg::CMD_MUL: r.elem = gf_product(n, am, b);
            gfmpi_pkg::CMD_POW: r.elem = gf_power(n, am, e);
            gfmpi_pkg::CMD_INV: begin
                if (am == '0) begin
                    r.err = 1'b1;
                end else begin
                    inv_exp = ((64'd1 << (n - 1)) - 64'd1) << 1;
                    r.elem = gf_power(n, am, inv_exp);
                end
            end
            default: ;
        endcase
        r.elem = r.elem & elem_mask(n);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Element values lean toward zero, one and all ones; the rest are full width.
    function automatic logic [DATA_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 64'd1;
            2: return ALL_ONES;
            default: return rand64();
        endcase
    endfunction

    // Exponents are mostly short so that powers stay quick; some run to max_bits.
    function automatic logic [DATA_W-1:0] rand_exponent(int max_bits);
        int                sel;
        int                len;
        logic [DATA_W-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        len = (sel <= 2) ? max_bits : $urandom_range(1, (max_bits < 16) ? max_bits : 16);
        v = (sel == 2) ? ALL_ONES : rand64();
        return v >> (64 - len);
    endfunction

    function automatic gfmpi_pkg::t_cmd rand_cmd();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8) return gfmpi_pkg::CMD_MUL;
        if (r < 14) return gfmpi_pkg::CMD_POW;
        if (r < 19) return gfmpi_pkg::CMD_INV;
        return gfmpi_pkg::CMD_RSVD;
    endfunction

    // Present one request and hold it until the unit takes it.
    task automatic send_request(gfmpi_pkg::t_cmd cmd, logic [DATA_W-1:0] a,
                                logic [DATA_W-1:0] b, logic [DATA_W-1:0] e);
        @(negedge i_clk);
        start <= 1'b1;
        i_command <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        i_exponent <= e;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(field_result(cmd, a, b, e));
        n_sent++;
    endtask

    // Sender idles; the request fields carry noise meanwhile.
    task automatic idle_gap(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_command <= 2'($urandom);
            i_operand_a <= rand64();
            i_operand_b <= rand64();
            i_exponent <= rand64();
        end
    endtask

    task automatic pace();
        if (!steady && $urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 9));
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_results_done();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_degree(logic [DEG_W-1:0] v);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= DEG_W'($urandom);
        degree_cfg = v;
        n_settings++;
    endtask

    task automatic send_random_item(int max_bits);
        send_request(rand_cmd(), rand_elem(), rand_elem(), rand_exponent(max_bits));
        pace();
    endtask

    // Corner operands at the degree the unit comes out of reset with.
    task automatic test_directed_default();
        send_request(gfmpi_pkg::CMD_MUL, 64'hff, 64'hff, '0);
        send_request(gfmpi_pkg::CMD_MUL, ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(gfmpi_pkg::CMD_MUL, '0, rand64(), '0);
        send_request(gfmpi_pkg::CMD_POW, '0, '0, '0);
        send_request(gfmpi_pkg::CMD_POW, 64'h53, '0, '0);
        send_request(gfmpi_pkg::CMD_POW, rand64(), rand64(), ALL_ONES);
        send_request(gfmpi_pkg::CMD_INV, '0, ALL_ONES, ALL_ONES);
        // Nonzero only above the field width, so the inverse sees zero.
        send_request(gfmpi_pkg::CMD_INV, 64'hffff_ff00, '0, '0);
        send_request(gfmpi_pkg::CMD_INV, 64'd1, '0, '0);
        send_request(gfmpi_pkg::CMD_INV, 64'h53, '0, '0);
        send_request(gfmpi_pkg::CMD_RSVD, ALL_ONES, ALL_ONES, ALL_ONES);
    endtask

    // Degree zero acts as one, and values past 64 act as 64.
    task automatic test_degree_extremes();
        set_degree(DEG_W'(0));
        send_request(gfmpi_pkg::CMD_MUL, 64'd1, 64'd1, '0);
        send_request(gfmpi_pkg::CMD_MUL, ALL_ONES, 64'd2, '0);
        send_request(gfmpi_pkg::CMD_POW, 64'd1, '0, rand64());
        send_request(gfmpi_pkg::CMD_INV, 64'd1, '0, '0);
        send_request(gfmpi_pkg::CMD_INV, '0, '0, '0);
        send_request(gfmpi_pkg::CMD_INV, 64'd2, '0, '0);
        set_degree(DEG_W'(127));
        send_request(gfmpi_pkg::CMD_MUL, ALL_ONES, ALL_ONES, '0);
        send_request(gfmpi_pkg::CMD_POW, rand64(), '0, ALL_ONES);
        send_request(gfmpi_pkg::CMD_INV, rand64() | 64'd1, '0, '0);
        set_degree(DEG_W'(64));
        send_request(gfmpi_pkg::CMD_MUL, rand64(), rand64(), '0);
        send_request(gfmpi_pkg::CMD_RSVD, rand64(), rand64(), rand64());
        set_degree(DEG_W'(65));
        send_request(gfmpi_pkg::CMD_MUL, rand64(), rand64(), rand64());
    endtask

    // Random requests over a series of small degrees, with pauses and idle-free stretches.
    task automatic test_random_small();
        int sel;
        for (int phase = 0; phase < 12; phase++) begin
            sel = $urandom_range(0, 7);
            set_degree((sel == 0) ? DEG_W'(0) : (sel == 1) ? DEG_W'(1)
                                              : DEG_W'($urandom_range(2, 20)));
            steady = (phase % 4 == 3);
            for (int k = 0; k < 55; k++) begin
                if (k == 25 && phase % 2 == 0) wait_results_done();
                send_random_item(64);
            end
        end
        steady = 1'b0;
    endtask

    // A few requests at wide degrees, where each multiply takes longer.
    task automatic test_random_wide();
        logic [DEG_W-1:0] wide [0:2];
        wide[0] = DEG_W'(40);
        wide[1] = DEG_W'(63);
        wide[2] = DEG_W'(100);
        for (int w = 0; w < 3; w++) begin
            set_degree(wide[w]);
            repeat (8) send_random_item(8);
        end
    endtask

    // Final stretch: requests back to back with no idling.
    task automatic test_back_to_back();
        set_degree(DEG_W'($urandom_range(2, 12)));
        steady = 1'b1;
        repeat (100) send_random_item(16);
    endtask

    // Compare every result with the oldest expectation.
    always @(posedge i_clk) begin
        t_field_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: result %h error %b",
                       o_result, o_error);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_result !== want.elem) begin
                    $error("result: expected %h, actual %h", want.elem, o_result);
                    n_fail++;
                end
                if (o_error !== want.err) begin
                    $error("error: expected %b, actual %b", want.err, o_error);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Reset, then the tests in turn, then the drain and the verdict.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        start = 1'b0;
        i_command = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        i_exponent = '0;
        degree_cfg = DEG_W'(8);
        n_sent = 0;
        n_checked = 0;
        n_fail = 0;
        n_settings = 0;
        quiet_cycles = 0;
        steady = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_default();
        test_degree_extremes();
        test_random_small();
        test_random_wide();
        test_back_to_back();

        wait_results_done();
        repeat (64) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_fail++;
        end
        $display("Run covered %0d requests (multiply, power, inverse, unused command)",
                 n_sent);
        $display("and %0d checked results across %0d degree register writes.",
                 n_checked, n_settings);
        if (n_fail == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
